[design/qftv_pkg.sv]
package qftv_pkg;

    localparam int IN_W        = 16;
    localparam int OUT_W       = 16;
    localparam int FRAC_BITS   = 14;
    localparam int LANES       = 4;
    localparam int WIDE_W      = 64;
    localparam int MAG_W       = 63;
    localparam int SCALE_MSB   = 29;
    localparam int NORM_W      = SCALE_MSB + 1;
    localparam int RAD_W       = 62;
    localparam int ROOT_W      = 31;
    localparam int QUO_W       = FRAC_BITS + 1;
    localparam int NUM_W       = NORM_W + FRAC_BITS + 1;
    localparam int SQRT_STAGES = ROOT_W;
    localparam int DIV_STAGES  = QUO_W;
    localparam int NORM_STAGES = 3;

    // stage numbering of the pipeline, counted from the input register
    localparam int ST_S2   = 2;
    localparam int SD2_LEN = 3 + SQRT_STAGES;
    localparam int LAT     = 3 + SQRT_STAGES + 2 + NORM_STAGES + 3 + SQRT_STAGES + 1
                             + DIV_STAGES;

    localparam logic signed [OUT_W-1:0] Q_ONE = OUT_W'(1 << FRAC_BITS);

    typedef struct packed {
        logic valid;
        logic deg;
    } t_tag;

    typedef struct packed {
        logic signed [WIDE_W-1:0] px;
        logic signed [WIDE_W-1:0] py;
        logic signed [WIDE_W-1:0] pz;
        logic signed [WIDE_W-1:0] dot;
    } t_cross_dot;

    typedef struct packed {
        logic [LANES-1:0][NORM_W-1:0] mag;
        logic [LANES-1:0]             neg;
    } t_lanes;

    typedef struct packed {
        logic signed [OUT_W-1:0] w;
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic signed [OUT_W-1:0] z;
        logic                    deg;
    } t_result;

endpackage

[design/quaternion_from_two_vectors.sv]
// rotation quaternion that turns the direction of u onto the direction of v
// input channel: i_valid/o_stall with the six signed vector components; a
// transaction is taken at a clock edge with i_valid high and o_stall low
// output channel: o_valid/i_stall with quat_w/x/y/z in Q1.14 and a degenerate
// flag; degenerate (zero vector, parallel or antiparallel) returns identity
// throughput: one transaction per cycle while o_stall is low, fully pipelined
// the delay from input transaction to o_valid is set by the 31-stage square
// root pipelines (two in series), the 15-stage divider and the front end,
// normalize and sum-of-squares stages around them
// i_stall with a result waiting parks the next result in a skid register;
// only while that register is full does o_stall rise and the pipeline hold,
// so nothing is dropped or repeated
// reset: synchronous, active low on i_rst_n; clears all valid bits, the output
// valid and the skid full flag, so the block comes up empty and ready
module quaternion_from_two_vectors (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [qftv_pkg::IN_W-1:0]    i_u_x,
    input  logic signed [qftv_pkg::IN_W-1:0]    i_u_y,
    input  logic signed [qftv_pkg::IN_W-1:0]    i_u_z,
    input  logic signed [qftv_pkg::IN_W-1:0]    i_v_x,
    input  logic signed [qftv_pkg::IN_W-1:0]    i_v_y,
    input  logic signed [qftv_pkg::IN_W-1:0]    i_v_z,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [qftv_pkg::OUT_W-1:0]   o_quat_w,
    output logic signed [qftv_pkg::OUT_W-1:0]   o_quat_x,
    output logic signed [qftv_pkg::OUT_W-1:0]   o_quat_y,
    output logic signed [qftv_pkg::OUT_W-1:0]   o_quat_z,
    output logic                                o_degenerate
);
    import qftv_pkg::*;

    function automatic logic [3:0] msb16(input logic [IN_W-1:0] v);
        logic [3:0] p;
        p = '0;
        for (int i = 0; i < IN_W; i++) begin
            if (v[i]) p = 4'(i);
        end
        return p;
    endfunction

    function automatic logic [IN_W-1:0] mag16(input logic signed [IN_W-1:0] v);
        return v[IN_W-1] ? IN_W'(-v) : IN_W'(v);
    endfunction

    logic en;
    t_tag r_tag [LAT];

    // stage 0: input register
    logic signed [IN_W-1:0] r_s0_u [3];
    logic signed [IN_W-1:0] r_s0_v [3];

    // stage 1: products of the raw vectors and block scale shifts
    logic signed [IN_W*2:0]   r_s1_cx, r_s1_cy, r_s1_cz;
    logic signed [IN_W*2+1:0] r_s1_dot;
    logic [IN_W*2-1:0]        r_s1_nu, r_s1_nv;
    logic [4:0]               r_s1_sa, r_s1_sb;

    logic signed [IN_W*2-1:0] p_yz, p_zy, p_zx, p_xz, p_xy, p_yx;
    logic signed [IN_W*2-1:0] p_dx, p_dy, p_dz;
    logic signed [IN_W*2-1:0] p_ux, p_uy, p_uz, p_vx, p_vy, p_vz;
    logic [4:0]               sa, sb;

    always_comb begin
        p_yz = r_s0_u[1] * r_s0_v[2];
        p_zy = r_s0_u[2] * r_s0_v[1];
        p_zx = r_s0_u[2] * r_s0_v[0];
        p_xz = r_s0_u[0] * r_s0_v[2];
        p_xy = r_s0_u[0] * r_s0_v[1];
        p_yx = r_s0_u[1] * r_s0_v[0];
        p_dx = r_s0_u[0] * r_s0_v[0];
        p_dy = r_s0_u[1] * r_s0_v[1];
        p_dz = r_s0_u[2] * r_s0_v[2];
        p_ux = r_s0_u[0] * r_s0_u[0];
        p_uy = r_s0_u[1] * r_s0_u[1];
        p_uz = r_s0_u[2] * r_s0_u[2];
        p_vx = r_s0_v[0] * r_s0_v[0];
        p_vy = r_s0_v[1] * r_s0_v[1];
        p_vz = r_s0_v[2] * r_s0_v[2];
        // top magnitude bit goes to SCALE_MSB
        sa = 5'(SCALE_MSB - int'(msb16(mag16(r_s0_u[0]) | mag16(r_s0_u[1])
                                       | mag16(r_s0_u[2]))));
        sb = 5'(SCALE_MSB - int'(msb16(mag16(r_s0_v[0]) | mag16(r_s0_v[1])
                                       | mag16(r_s0_v[2]))));
    end

    // stage 2: scaled cross, dot and squared norms (left shifts are exact)
    t_cross_dot             r_s2_pd;
    logic [RAD_W-1:0]       r_s2_xa, r_s2_xb;
    logic [5:0]             sh;
    logic [WIDE_W-1:0]      xa_w, xb_w;
    logic                   deg_s2;

    always_comb begin
        sh     = 6'(r_s1_sa) + 6'(r_s1_sb);
        xa_w   = WIDE_W'(r_s1_nu) << {r_s1_sa, 1'b0};
        xb_w   = WIDE_W'(r_s1_nv) << {r_s1_sb, 1'b0};
        deg_s2 = (r_s1_cx == '0) && (r_s1_cy == '0) && (r_s1_cz == '0);
    end

    logic [ROOT_W-1:0] ra, rb, rq;

    qftv_isqrt u_sqrt_a (.i_clk(i_clk), .i_en(en), .i_rad(r_s2_xa), .o_root(ra));
    qftv_isqrt u_sqrt_b (.i_clk(i_clk), .i_en(en), .i_rad(r_s2_xb), .o_root(rb));

    t_cross_dot r_sd1 [SQRT_STAGES];

    // M1, M2: scalar part |a||b| + a.b, clamped at zero, and cross product magnitudes and signs
    logic [RAD_W-1:0]              r_m1_prod;
    t_cross_dot                    r_m1_pd;
    logic [LANES-1:0][MAG_W-1:0]   r_m2_mag;
    logic [LANES-1:0]              r_m2_neg;
    logic signed [WIDE_W-1:0]      wsum;
    logic signed [WIDE_W-1:0]      ax, ay, az;

    always_comb begin
        wsum = $signed({2'b00, r_m1_prod}) + r_m1_pd.dot;
        ax   = r_m1_pd.px[WIDE_W-1] ? -r_m1_pd.px : r_m1_pd.px;
        ay   = r_m1_pd.py[WIDE_W-1] ? -r_m1_pd.py : r_m1_pd.py;
        az   = r_m1_pd.pz[WIDE_W-1] ? -r_m1_pd.pz : r_m1_pd.pz;
    end

    logic [LANES-1:0][NORM_W-1:0] nm_mag;
    logic [LANES-1:0]             nm_neg;

    qftv_norm u_norm (
        .i_clk (i_clk),
        .i_en  (en),
        .i_mag (r_m2_mag),
        .i_neg (r_m2_neg),
        .o_mag (nm_mag),
        .o_neg (nm_neg)
    );

    // Q1..Q3: sum of squares of the normalized quaternion
    logic [LANES-1:0][2*NORM_W-1:0] r_q1_sq;
    logic [2*NORM_W:0]              r_q2_a, r_q2_b;
    logic [RAD_W-1:0]               r_q3_sum;
    t_lanes                         r_sd2 [SD2_LEN];

    qftv_isqrt u_sqrt_q (.i_clk(i_clk), .i_en(en), .i_rad(r_q3_sum), .o_root(rq));

    // D0: rounded numerators over the norm
    logic [LANES-1:0][NUM_W-1:0] r_d0_num;
    logic [ROOT_W-1:0]           r_d0_den;
    logic [LANES-1:0]            r_d0_neg;
    logic [ROOT_W-1:0]           den;
    logic [LANES-1:0][NUM_W-1:0] num;
    t_lanes                      sd2_last;

    always_comb begin
        sd2_last = r_sd2[SD2_LEN-1];
        den      = (rq == '0) ? ROOT_W'(1) : rq;
        for (int i = 0; i < LANES; i++) begin
            num[i] = (NUM_W'(sd2_last.mag[i]) << FRAC_BITS) + NUM_W'(den >> 1);
        end
    end

    logic [LANES-1:0][QUO_W-1:0] quo;
    logic [LANES-1:0]            r_sd3 [DIV_STAGES];

    qftv_div u_div (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_d0_num),
        .i_den (r_d0_den),
        .o_quo (quo)
    );

    // final sign and identity selection
    t_result                    pres;
    logic                       pvalid;
    logic [LANES-1:0][OUT_W-1:0] qs;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            qs[i] = r_sd3[DIV_STAGES-1][i] ? OUT_W'(-OUT_W'(quo[i])) : OUT_W'(quo[i]);
        end
        pvalid = r_tag[LAT-1].valid;
        if (r_tag[LAT-1].deg) begin
            pres = '{w: Q_ONE, x: '0, y: '0, z: '0, deg: 1'b1};
        end else begin
            pres = '{w: $signed(qs[0]), x: $signed(qs[1]), y: $signed(qs[2]),
                     z: $signed(qs[3]), deg: 1'b0};
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_u[0] <= i_u_x;
            r_s0_u[1] <= i_u_y;
            r_s0_u[2] <= i_u_z;
            r_s0_v[0] <= i_v_x;
            r_s0_v[1] <= i_v_y;
            r_s0_v[2] <= i_v_z;

            r_s1_cx  <= (IN_W*2+1)'(p_yz) - (IN_W*2+1)'(p_zy);
            r_s1_cy  <= (IN_W*2+1)'(p_zx) - (IN_W*2+1)'(p_xz);
            r_s1_cz  <= (IN_W*2+1)'(p_xy) - (IN_W*2+1)'(p_yx);
            r_s1_dot <= (IN_W*2+2)'(p_dx) + (IN_W*2+2)'(p_dy) + (IN_W*2+2)'(p_dz);
            r_s1_nu  <= $unsigned(p_ux) + $unsigned(p_uy) + $unsigned(p_uz);
            r_s1_nv  <= $unsigned(p_vx) + $unsigned(p_vy) + $unsigned(p_vz);
            r_s1_sa  <= sa;
            r_s1_sb  <= sb;

            r_s2_pd.px  <= WIDE_W'(r_s1_cx) << sh;
            r_s2_pd.py  <= WIDE_W'(r_s1_cy) << sh;
            r_s2_pd.pz  <= WIDE_W'(r_s1_cz) << sh;
            r_s2_pd.dot <= WIDE_W'(r_s1_dot) << sh;
            r_s2_xa     <= xa_w[RAD_W-1:0];
            r_s2_xb     <= xb_w[RAD_W-1:0];

            r_sd1[0] <= r_s2_pd;
            for (int i = 1; i < SQRT_STAGES; i++) r_sd1[i] <= r_sd1[i-1];

            r_m1_prod <= RAD_W'(ra) * RAD_W'(rb);
            r_m1_pd   <= r_sd1[SQRT_STAGES-1];

            r_m2_mag[0] <= wsum[WIDE_W-1] ? '0 : wsum[MAG_W-1:0];
            r_m2_mag[1] <= ax[MAG_W-1:0];
            r_m2_mag[2] <= ay[MAG_W-1:0];
            r_m2_mag[3] <= az[MAG_W-1:0];
            r_m2_neg    <= {r_m1_pd.pz[WIDE_W-1], r_m1_pd.py[WIDE_W-1],
                            r_m1_pd.px[WIDE_W-1], 1'b0};

            for (int i = 0; i < LANES; i++) begin
                r_q1_sq[i] <= (2*NORM_W)'(nm_mag[i]) * (2*NORM_W)'(nm_mag[i]);
            end
            r_q2_a   <= (2*NORM_W+1)'(r_q1_sq[0]) + (2*NORM_W+1)'(r_q1_sq[1]);
            r_q2_b   <= (2*NORM_W+1)'(r_q1_sq[2]) + (2*NORM_W+1)'(r_q1_sq[3]);
            r_q3_sum <= RAD_W'(r_q2_a) + RAD_W'(r_q2_b);

            r_sd2[0] <= '{mag: nm_mag, neg: nm_neg};
            for (int i = 1; i < SD2_LEN; i++) r_sd2[i] <= r_sd2[i-1];

            r_d0_num <= num;
            r_d0_den <= den;
            r_d0_neg <= sd2_last.neg;

            r_sd3[0] <= r_d0_neg;
            for (int i = 1; i < DIV_STAGES; i++) r_sd3[i] <= r_sd3[i-1];
        end
    end

    // valid and degenerate bits travel alongside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LAT; i++) r_tag[i] <= '0;
        end else if (en) begin
            r_tag[0] <= '{valid: i_valid, deg: 1'b0};
            for (int i = 1; i < LAT; i++) begin
                if (i == ST_S2) begin
                    r_tag[i] <= '{valid: r_tag[i-1].valid, deg: deg_s2};
                end else begin
                    r_tag[i] <= r_tag[i-1];
                end
            end
        end
    end

    // output register plus one skid entry
    t_result r_out, r_skid;
    logic    r_ovalid, r_skid_full;
    logic    n_ovalid, n_skid_full;
    logic    out_free;

    assign en       = !r_skid_full;
    assign out_free = !r_ovalid || !i_stall;

    always_comb begin
        n_ovalid    = r_ovalid;
        n_skid_full = r_skid_full;
        if (r_skid_full) begin
            if (out_free) begin
                n_ovalid    = 1'b1;
                n_skid_full = 1'b0;
            end
        end else if (out_free) begin
            n_ovalid = pvalid;
        end else if (pvalid) begin
            n_skid_full = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid    <= 1'b0;
            r_skid_full <= 1'b0;
        end else begin
            r_ovalid    <= n_ovalid;
            r_skid_full <= n_skid_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_full) begin
            if (out_free) r_out <= r_skid;
        end else if (out_free) begin
            r_out <= pres;
        end else if (pvalid) begin
            r_skid <= pres;
        end
    end

    assign o_stall      = r_skid_full;
    assign o_valid      = r_ovalid;
    assign o_quat_w     = r_out.w;
    assign o_quat_x     = r_out.x;
    assign o_quat_y     = r_out.y;
    assign o_quat_z     = r_out.z;
    assign o_degenerate = r_out.deg;

    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_full |-> r_ovalid)
        else $error("skid holds a result while the output register is empty");

    a_skid_fill_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_full) |-> $past(r_ovalid && i_stall))
        else $error("skid filled without a stalled output");

    a_degenerate_identity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_degenerate) |-> (o_quat_w == Q_ONE && o_quat_x == '0
                                       && o_quat_y == '0 && o_quat_z == '0))
        else $error("degenerate result is not the identity");

    a_scalar_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_quat_w[OUT_W-1])
        else $error("scalar part negative");

endmodule

[design/qftv_isqrt.sv]
module qftv_isqrt (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [qftv_pkg::RAD_W-1:0]   i_rad,
    output logic [qftv_pkg::ROOT_W-1:0]  o_root
);
    import qftv_pkg::*;

    logic [RAD_W-1:0]  r_rem  [SQRT_STAGES];
    logic [ROOT_W-1:0] r_root [SQRT_STAGES];

    logic [RAD_W-1:0]  rem_src  [SQRT_STAGES];
    logic [ROOT_W-1:0] root_src [SQRT_STAGES];
    logic [RAD_W-1:0]  rem_nx   [SQRT_STAGES];
    logic [ROOT_W-1:0] root_nx  [SQRT_STAGES];
    logic [WIDE_W-1:0] trial    [SQRT_STAGES];
    logic              fits     [SQRT_STAGES];

    // one root bit per stage, most significant first
    always_comb begin
        rem_src[0]  = i_rad;
        root_src[0] = '0;
        for (int j = 1; j < SQRT_STAGES; j++) begin
            rem_src[j]  = r_rem[j-1];
            root_src[j] = r_root[j-1];
        end
        for (int j = 0; j < SQRT_STAGES; j++) begin
            trial[j] = (WIDE_W'(root_src[j]) << (SQRT_STAGES - j))
                     | (WIDE_W'(1) << (2 * (SQRT_STAGES - 1 - j)));
            fits[j]  = WIDE_W'(rem_src[j]) >= trial[j];
            rem_nx[j]  = fits[j] ? rem_src[j] - trial[j][RAD_W-1:0] : rem_src[j];
            root_nx[j] = fits[j] ? (root_src[j] | (ROOT_W'(1) << (SQRT_STAGES - 1 - j)))
                                 : root_src[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < SQRT_STAGES; j++) begin
                r_rem[j]  <= rem_nx[j];
                r_root[j] <= root_nx[j];
            end
        end
    end

    assign o_root = r_root[SQRT_STAGES-1];

endmodule

[design/qftv_norm.sv]
module qftv_norm (
    input  logic                                            i_clk,
    input  logic                                            i_en,
    input  logic [qftv_pkg::LANES-1:0][qftv_pkg::MAG_W-1:0] i_mag,
    input  logic [qftv_pkg::LANES-1:0]                      i_neg,
    output logic [qftv_pkg::LANES-1:0][qftv_pkg::NORM_W-1:0] o_mag,
    output logic [qftv_pkg::LANES-1:0]                      o_neg
);
    import qftv_pkg::*;

    logic [LANES-1:0][MAG_W-1:0]  r1_mag;
    logic [LANES-1:0]             r1_neg;
    logic [7:0]                   r1_gnz;
    logic [7:0][2:0]              r1_gpos;
    logic [LANES-1:0][MAG_W-1:0]  r2_mag;
    logic [LANES-1:0]             r2_neg;
    logic                         r2_left;
    logic [5:0]                   r2_amt;
    logic [LANES-1:0][NORM_W-1:0] r3_mag;
    logic [LANES-1:0]             r3_neg;

    logic [WIDE_W-1:0]            orv;
    logic [7:0]                   gnz;
    logic [7:0][2:0]              gpos;
    logic [5:0]                   msb;
    logic                         left;
    logic [5:0]                   amt;
    logic [LANES-1:0][MAG_W-1:0]  shifted;

    // the or of all magnitudes has its top bit where the largest one has
    always_comb begin
        orv = WIDE_W'(i_mag[0] | i_mag[1] | i_mag[2] | i_mag[3]);
        for (int g = 0; g < 8; g++) begin
            gnz[g]  = |orv[g*8 +: 8];
            gpos[g] = '0;
            for (int b = 0; b < 8; b++) begin
                if (orv[g*8 + b]) gpos[g] = 3'(b);
            end
        end
    end

    always_comb begin
        msb = '0;
        for (int g = 0; g < 8; g++) begin
            if (r1_gnz[g]) msb = {3'(g), r1_gpos[g]};
        end
        left = msb < 6'(SCALE_MSB);
        amt  = left ? 6'(SCALE_MSB) - msb : msb - 6'(SCALE_MSB);
    end

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            shifted[i] = r2_left ? (r2_mag[i] << r2_amt) : (r2_mag[i] >> r2_amt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_mag  <= i_mag;
            r1_neg  <= i_neg;
            r1_gnz  <= gnz;
            r1_gpos <= gpos;
            r2_mag  <= r1_mag;
            r2_neg  <= r1_neg;
            r2_left <= left;
            r2_amt  <= amt;
            for (int i = 0; i < LANES; i++) begin
                r3_mag[i] <= shifted[i][NORM_W-1:0];
            end
            r3_neg  <= r2_neg;
        end
    end

    assign o_mag = r3_mag;
    assign o_neg = r3_neg;

endmodule

[design/qftv_div.sv]
module qftv_div (
    input  logic                                            i_clk,
    input  logic                                            i_en,
    input  logic [qftv_pkg::LANES-1:0][qftv_pkg::NUM_W-1:0] i_num,
    input  logic [qftv_pkg::ROOT_W-1:0]                     i_den,
    output logic [qftv_pkg::LANES-1:0][qftv_pkg::QUO_W-1:0] o_quo
);
    import qftv_pkg::*;

    logic [LANES-1:0][NUM_W-1:0] r_num [DIV_STAGES];
    logic [LANES-1:0][QUO_W-1:0] r_quo [DIV_STAGES];
    logic [ROOT_W-1:0]           r_den [DIV_STAGES];

    logic [LANES-1:0][NUM_W-1:0] num_src [DIV_STAGES];
    logic [LANES-1:0][QUO_W-1:0] quo_src [DIV_STAGES];
    logic [ROOT_W-1:0]           den_src [DIV_STAGES];
    logic [LANES-1:0][NUM_W-1:0] num_nx  [DIV_STAGES];
    logic [LANES-1:0][QUO_W-1:0] quo_nx  [DIV_STAGES];
    logic [NUM_W:0]              trial   [DIV_STAGES];

    // restoring division, one quotient bit per stage; quotient fits QUO_W bits
    always_comb begin
        num_src[0] = i_num;
        quo_src[0] = '0;
        den_src[0] = i_den;
        for (int j = 1; j < DIV_STAGES; j++) begin
            num_src[j] = r_num[j-1];
            quo_src[j] = r_quo[j-1];
            den_src[j] = r_den[j-1];
        end
        for (int j = 0; j < DIV_STAGES; j++) begin
            trial[j] = (NUM_W+1)'(den_src[j]) << (DIV_STAGES - 1 - j);
            for (int i = 0; i < LANES; i++) begin
                if ((NUM_W+1)'(num_src[j][i]) >= trial[j]) begin
                    num_nx[j][i] = num_src[j][i] - trial[j][NUM_W-1:0];
                    quo_nx[j][i] = quo_src[j][i] | (QUO_W'(1) << (DIV_STAGES - 1 - j));
                end else begin
                    num_nx[j][i] = num_src[j][i];
                    quo_nx[j][i] = quo_src[j][i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < DIV_STAGES; j++) begin
                r_num[j] <= num_nx[j];
                r_quo[j] <= quo_nx[j];
                r_den[j] <= den_src[j];
            end
        end
    end

    assign o_quo = r_quo[DIV_STAGES-1];

endmodule
